[rtl/zyz_pkg.sv]
// package for the zyz euler angle to rotation matrix pipeline
// holds payload structs, cordic constants and the output rounding function
// no dependencies
`default_nettype none

package zyz_pkg;

    // fixed field formats
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 15;
    localparam int OUT_BITS     = FRAC_BITS + 1;

    // cordic datapath formats
    localparam int CORDIC_ITERS = 30;
    localparam int XY_BITS      = 34;
    localparam int Z_BITS       = 33;
    localparam int CS_BITS      = 32;
    localparam int P_BITS       = 64;
    localparam int LANES        = 3;
    localparam logic signed [XY_BITS-1:0] CORDIC_X0 = 34'sd652032874;

    // arctangent of 2^-i on a 2^32 per turn scale
    localparam int ATAN_TURN [CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1};

    typedef struct packed {
        logic [ANGLE_BITS-1:0] first_angle;
        logic [ANGLE_BITS-1:0] second_angle;
        logic [ANGLE_BITS-1:0] third_angle;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] row0_col0;
        logic signed [OUT_BITS-1:0] row0_col1;
        logic signed [OUT_BITS-1:0] row0_col2;
        logic signed [OUT_BITS-1:0] row1_col0;
        logic signed [OUT_BITS-1:0] row1_col1;
        logic signed [OUT_BITS-1:0] row1_col2;
        logic signed [OUT_BITS-1:0] row2_col0;
        logic signed [OUT_BITS-1:0] row2_col1;
        logic signed [OUT_BITS-1:0] row2_col2;
    } matrix_t;

    // round a q60 value half up to the output format and saturate
    function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [P_BITS-1:0] p);
        logic signed [P_BITS-1:0] v;
        logic signed [P_BITS-1:0] hi;
        logic signed [P_BITS-1:0] lo;
        hi = (P_BITS'(1) <<< FRAC_BITS) - P_BITS'(1);
        lo = -(P_BITS'(1) <<< FRAC_BITS);
        v  = (p + (P_BITS'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/zyz_euler_to_rotation_matrix.sv]
// throughput: one transaction per cycle unless the output stalls, set by the 30-stage unrolled cordic per angle
// and the four multiply/add stages that follow; every stage holds a valid bit
// and a stalled output backs pressure stage by stage, so bubbles are squeezed out
// reset: rst_n asynchronous active low clears all stage valid bits; payload is not reset
// depends on zyz_pkg
`default_nettype none

module zyz_euler_to_rotation_matrix (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             angles_valid,
    output logic                  angles_ready,
    input  wire zyz_pkg::angles_t angles,
    output logic                  matrix_valid,
    input  wire logic             matrix_ready,
    output zyz_pkg::matrix_t      matrix
);

    localparam int ITERS = zyz_pkg::CORDIC_ITERS;
    localparam int QUAD  = ITERS + 1;
    localparam int M1    = ITERS + 2;
    localparam int M2    = ITERS + 3;
    localparam int M3    = ITERS + 4;
    localparam int M4    = ITERS + 5;
    localparam int NSTG  = ITERS + 7;

    localparam int XW = zyz_pkg::XY_BITS;
    localparam int ZW = zyz_pkg::Z_BITS;
    localparam int CW = zyz_pkg::CS_BITS;
    localparam int PW = zyz_pkg::P_BITS;
    localparam int NL = zyz_pkg::LANES;

    // stage valid bits and the ready chain
    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    always_comb
    begin
        rdy[NSTG] = matrix_ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= angles_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign angles_ready = rdy[0];
    assign matrix_valid = v_reg[NSTG-1];

    // cordic lane registers, index 0 is the fold stage
    logic signed [XW-1:0] x_reg [ITERS+1][NL];
    logic signed [XW-1:0] y_reg [ITERS+1][NL];
    logic signed [ZW-1:0] z_reg [ITERS+1][NL];
    logic [1:0]           q_reg [ITERS+1][NL];

    logic [zyz_pkg::ANGLE_BITS-1:0] ang [NL];
    assign ang[0] = angles.first_angle;
    assign ang[1] = angles.second_angle;
    assign ang[2] = angles.third_angle;

    // fold each angle to +-1/8 turn plus a quarter count
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int l = 0; l < NL; l++)
            begin
                logic [31:0] t;
                t = {ang[l], {(32 - zyz_pkg::ANGLE_BITS){1'b0}}} + 32'h2000_0000;
                q_reg[0][l] <= t[31:30];
                z_reg[0][l] <= $signed({{(ZW - 30){1'b0}}, t[29:0]}) - ZW'(536870912);
                x_reg[0][l] <= zyz_pkg::CORDIC_X0;
                y_reg[0][l] <= '0;
            end
        end
    end

    // one cordic iteration per stage
    for (genvar gi = 0; gi < ITERS; gi++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (rdy[gi+1])
            begin
                for (int l = 0; l < NL; l++)
                begin
                    q_reg[gi+1][l] <= q_reg[gi][l];
                    if (z_reg[gi][l] >= 0)
                    begin
                        x_reg[gi+1][l] <= x_reg[gi][l] - (y_reg[gi][l] >>> gi);
                        y_reg[gi+1][l] <= y_reg[gi][l] + (x_reg[gi][l] >>> gi);
                        z_reg[gi+1][l] <= z_reg[gi][l] - ZW'(zyz_pkg::ATAN_TURN[gi]);
                    end
                    else
                    begin
                        x_reg[gi+1][l] <= x_reg[gi][l] + (y_reg[gi][l] >>> gi);
                        y_reg[gi+1][l] <= y_reg[gi][l] - (x_reg[gi][l] >>> gi);
                        z_reg[gi+1][l] <= z_reg[gi][l] + ZW'(zyz_pkg::ATAN_TURN[gi]);
                    end
                end
            end
        end
    end

    // quadrant restore into cosine and sine
    logic signed [CW-1:0] c_reg [NL];
    logic signed [CW-1:0] s_reg [NL];

    always_ff @(posedge clk)
    begin
        if (rdy[QUAD])
        begin
            for (int l = 0; l < NL; l++)
            begin
                logic signed [XW-1:0] x;
                logic signed [XW-1:0] y;
                x = x_reg[ITERS][l];
                y = y_reg[ITERS][l];
                unique case (q_reg[ITERS][l])
                    2'd0:
                    begin
                        c_reg[l] <= CW'(x);
                        s_reg[l] <= CW'(y);
                    end
                    2'd1:
                    begin
                        c_reg[l] <= CW'(-y);
                        s_reg[l] <= CW'(x);
                    end
                    2'd2:
                    begin
                        c_reg[l] <= CW'(-x);
                        s_reg[l] <= CW'(-y);
                    end
                    default:
                    begin
                        c_reg[l] <= CW'(y);
                        s_reg[l] <= CW'(-x);
                    end
                endcase
            end
        end
    end

    // first products in q60
    logic signed [PW-1:0] c1c2_reg, c2s1_reg, s1s3_reg, c3s1_reg, c1s2_reg;
    logic signed [PW-1:0] c1s3_reg, c1c3_reg, s1s2_reg, c3s2_reg, s2s3_reg;
    logic signed [CW-1:0] c2_m1_reg, c3_m1_reg, s3_m1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[M1])
        begin
            c1c2_reg  <= PW'(c_reg[0]) * PW'(c_reg[1]);
            c2s1_reg  <= PW'(c_reg[1]) * PW'(s_reg[0]);
            s1s3_reg  <= PW'(s_reg[0]) * PW'(s_reg[2]);
            c3s1_reg  <= PW'(c_reg[2]) * PW'(s_reg[0]);
            c1s2_reg  <= PW'(c_reg[0]) * PW'(s_reg[1]);
            c1s3_reg  <= PW'(c_reg[0]) * PW'(s_reg[2]);
            c1c3_reg  <= PW'(c_reg[0]) * PW'(c_reg[2]);
            s1s2_reg  <= PW'(s_reg[0]) * PW'(s_reg[1]);
            c3s2_reg  <= PW'(c_reg[2]) * PW'(s_reg[1]);
            s2s3_reg  <= PW'(s_reg[1]) * PW'(s_reg[2]);
            c2_m1_reg <= c_reg[1];
            c3_m1_reg <= c_reg[2];
            s3_m1_reg <= s_reg[2];
        end
    end

    // round c1c2 and c2s1 back to q30
    logic signed [CW-1:0] r_c1c2_reg, r_c2s1_reg, c2_m2_reg, c3_m2_reg, s3_m2_reg;
    logic signed [PW-1:0] s1s3_m2_reg, c3s1_m2_reg, c1s2_m2_reg, c1s3_m2_reg;
    logic signed [PW-1:0] c1c3_m2_reg, s1s2_m2_reg, c3s2_m2_reg, s2s3_m2_reg;
    logic signed [PW-1:0] rnd_c1c2, rnd_c2s1;

    assign rnd_c1c2 = (c1c2_reg + (PW'(1) <<< 29)) >>> 30;
    assign rnd_c2s1 = (c2s1_reg + (PW'(1) <<< 29)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (rdy[M2])
        begin
            r_c1c2_reg  <= CW'(rnd_c1c2);
            r_c2s1_reg  <= CW'(rnd_c2s1);
            c2_m2_reg   <= c2_m1_reg;
            c3_m2_reg   <= c3_m1_reg;
            s3_m2_reg   <= s3_m1_reg;
            s1s3_m2_reg <= s1s3_reg;
            c3s1_m2_reg <= c3s1_reg;
            c1s2_m2_reg <= c1s2_reg;
            c1s3_m2_reg <= c1s3_reg;
            c1c3_m2_reg <= c1c3_reg;
            s1s2_m2_reg <= s1s2_reg;
            c3s2_m2_reg <= c3s2_reg;
            s2s3_m2_reg <= s2s3_reg;
        end
    end

    // third-factor products
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [CW-1:0] c2_m3_reg;
    logic signed [PW-1:0] s1s3_m3_reg, c3s1_m3_reg, c1s2_m3_reg, c1s3_m3_reg;
    logic signed [PW-1:0] c1c3_m3_reg, s1s2_m3_reg, c3s2_m3_reg, s2s3_m3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[M3])
        begin
            pa_reg      <= PW'(r_c1c2_reg) * PW'(c3_m2_reg);
            pb_reg      <= PW'(r_c1c2_reg) * PW'(s3_m2_reg);
            pc_reg      <= PW'(r_c2s1_reg) * PW'(c3_m2_reg);
            pd_reg      <= PW'(r_c2s1_reg) * PW'(s3_m2_reg);
            c2_m3_reg   <= c2_m2_reg;
            s1s3_m3_reg <= s1s3_m2_reg;
            c3s1_m3_reg <= c3s1_m2_reg;
            c1s2_m3_reg <= c1s2_m2_reg;
            c1s3_m3_reg <= c1s3_m2_reg;
            c1c3_m3_reg <= c1c3_m2_reg;
            s1s2_m3_reg <= s1s2_m2_reg;
            c3s2_m3_reg <= c3s2_m2_reg;
            s2s3_m3_reg <= s2s3_m2_reg;
        end
    end

    // matrix entries in q60
    logic signed [PW-1:0] e_reg [9];

    always_ff @(posedge clk)
    begin
        if (rdy[M4])
        begin
            e_reg[0] <= pa_reg - s1s3_m3_reg;
            e_reg[1] <= -c3s1_m3_reg - pb_reg;
            e_reg[2] <= c1s2_m3_reg;
            e_reg[3] <= pc_reg + c1s3_m3_reg;
            e_reg[4] <= c1c3_m3_reg - pd_reg;
            e_reg[5] <= s1s2_m3_reg;
            e_reg[6] <= -c3s2_m3_reg;
            e_reg[7] <= s2s3_m3_reg;
            e_reg[8] <= PW'(c2_m3_reg) <<< 30;
        end
    end

    // round and saturate into the output register
    zyz_pkg::matrix_t matrix_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[NSTG-1])
        begin
            matrix_reg.row0_col0 <= zyz_pkg::to_out(e_reg[0]);
            matrix_reg.row0_col1 <= zyz_pkg::to_out(e_reg[1]);
            matrix_reg.row0_col2 <= zyz_pkg::to_out(e_reg[2]);
            matrix_reg.row1_col0 <= zyz_pkg::to_out(e_reg[3]);
            matrix_reg.row1_col1 <= zyz_pkg::to_out(e_reg[4]);
            matrix_reg.row1_col2 <= zyz_pkg::to_out(e_reg[5]);
            matrix_reg.row2_col0 <= zyz_pkg::to_out(e_reg[6]);
            matrix_reg.row2_col1 <= zyz_pkg::to_out(e_reg[7]);
            matrix_reg.row2_col2 <= zyz_pkg::to_out(e_reg[8]);
        end
    end

    assign matrix = matrix_reg;

    // an empty output stage means the whole pipe can move
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NSTG-1] |-> angles_ready)
        else $error("pipe stalled with empty output stage");

    // an accepted transaction lands in the fold stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (angles_valid && angles_ready) |=> v_reg[0])
        else $error("accepted transaction lost at fold stage");

    // a full last entry stage moving forward produces a result
    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[M4] && rdy[NSTG-1]) |=> matrix_valid)
        else $error("result lost at output stage");

    // a stalled result keeps its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (matrix_valid && !matrix_ready) |=> (matrix_valid && $stable(matrix)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
